### design/assert_macros.svh
// Assertion macros used by the LFU tag table core.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked on every clk edge outside reset
`define LFU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every clk edge, reset included
`define LFU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LFU_ASSERT(lbl, prop, msg)
`define LFU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### design/lfu_pkg.sv
// Shared types and constants for the LFU tag table.
// No dependencies; used by every module of the block.
package lfu_pkg;

	localparam int ENTRIES = 128;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CFG_W   = 8;
	localparam int LN_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int KEY_W   = 32;
	localparam int USE_W   = 32;
	localparam int CMP_W   = 32;   // keys and use counts share one comparator
	localparam int SLOT_W  = 7;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(10);

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

	typedef enum logic {
		CMP_EQ,
		CMP_LE
	} cmp_op_t;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] key_tag;
	} in_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
	} out_t;

	typedef struct packed {
		logic             key_we;
		logic             cnt_we;
		logic [IDX_W-1:0] addr;
		logic [KEY_W-1:0] key;
		logic [USE_W-1:0] cnt;
	} store_wr_t;

	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
		logic [USE_W-1:0] cnt;
	} store_rd_t;

endpackage

### design/lfu_cmp.sv
// Shared compare unit of the scan: equality for key match, less-or-equal for
// the minimum-count search. Depends on lfu_pkg.
module lfu_cmp
	import lfu_pkg::*;
(
	input  cmp_op_t          op,
	input  logic [CMP_W-1:0] a,
	input  logic [CMP_W-1:0] b,
	output logic             res
);

	always_comb begin
		unique case (op)
			CMP_EQ:  res = (a == b);
			CMP_LE:  res = (a <= b);
			default: res = 1'b0;
		endcase
	end

endmodule

### design/lfu_store.sv
// Entry storage: key and use-count memories with registered reads, plus
// per-entry occupied flags cleared by reset. Depends on lfu_pkg.
module lfu_store
	import lfu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output store_rd_t        rd,
	input  store_wr_t        wr
);

	logic [KEY_W-1:0] key_mem [ENTRIES];
	logic [USE_W-1:0] cnt_mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	store_rd_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[wr.addr] <= wr.key;
		end
		if (wr.cnt_we) begin
			cnt_mem[wr.addr] <= wr.cnt;
		end
		if (rd_en) begin
			rd_q.key <= key_mem[rd_addr];
			rd_q.cnt <= cnt_mem[rd_addr];
			rd_q.vld <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.key_we) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	assign rd = rd_q;

endmodule

### design/lfu_cache_tag_table_core.sv
// LFU tag table: a fully associative table of 32-bit key tags with
// least-frequently-used replacement. An item is a lookup or an insert; it is
// taken while the block is idle and runs a scan over the active entries, one
// entry per cycle through the key/count memories and one shared comparator.
// A lookup stops at the first hit or empty entry and an insert at the first
// empty entry; a lookup miss over all entries or an insert into a full table
// scans all N active entries (N = active_entries, 0 acting as 1, capped at
// 128). The block is ready for the next item in the same cycle that the
// result is presented.
// A finished result waits in an output register, so the next item can be
// taken while it is still held. No clearing pass is needed after reset.
// Depends on lfu_pkg, lfu_cmp, lfu_store and assert_macros.svh.
`include "assert_macros.svh"

module lfu_cache_tag_table_core
	import lfu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	state_t state_q, state_d;
	logic [CFG_W-1:0] active_q;
	logic [LN_W-1:0]  live_n;
	logic [LN_W-1:0]  rd_idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	in_t              req_q;
	logic [USE_W-1:0] low_q, low_d;
	logic [IDX_W-1:0] low_idx_q, low_idx_d;
	out_t             res_q, res_d;
	logic             out_valid_q;
	out_t             out_data_q;

	logic      issue, fin, last, take, out_load;
	store_rd_t rd;
	store_wr_t wr;
	cmp_op_t   cmp_op;
	logic [CMP_W-1:0] cmp_a, cmp_b;
	logic      cmp_res;

	lfu_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (issue),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd      (rd),
		.wr      (wr)
	);

	lfu_cmp u_cmp (
		.op  (cmp_op),
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

	// 0 acts as 1, anything above the table size is capped
	always_comb begin
		if (active_q == '0) begin
			live_n = LN_W'(1);
		end else if (LN_W'(active_q) > LN_W'(ENTRIES)) begin
			live_n = LN_W'(ENTRIES);
		end else begin
			live_n = LN_W'(active_q);
		end
	end

	assign cmp_op = (req_q.action == ACT_LOOKUP) ? CMP_EQ : CMP_LE;
	assign cmp_a  = (cmp_op == CMP_EQ) ? CMP_W'(rd.key) : CMP_W'(rd.cnt);
	assign cmp_b  = (cmp_op == CMP_EQ) ? CMP_W'(req_q.key_tag) : CMP_W'(low_q);
	assign last   = (LN_W'(idx_s1) == live_n - LN_W'(1));
	assign take   = cmp_res || (idx_s1 == '0);

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_RESULT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d   = state_q;
		fin       = 1'b0;
		res_d     = res_q;
		low_d     = low_q;
		low_idx_d = low_idx_q;
		wr        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (vld_s1) begin
					if (req_q.action == ACT_LOOKUP) begin
						if (!rd.vld) begin
							fin   = 1'b1;
							res_d = '0;
						end else if (cmp_res) begin
							fin        = 1'b1;
							res_d      = '0;
							res_d.hit  = 1'b1;
							res_d.slot = SLOT_W'(idx_s1);
							wr.cnt_we  = 1'b1;
							wr.addr    = idx_s1;
							wr.cnt     = (rd.cnt == '1) ? rd.cnt : rd.cnt + USE_W'(1);
						end else if (last) begin
							fin   = 1'b1;
							res_d = '0;
						end
					end else begin
						if (!rd.vld) begin
							fin        = 1'b1;
							res_d      = '0;
							res_d.slot = SLOT_W'(idx_s1);
							wr.key_we  = 1'b1;
							wr.cnt_we  = 1'b1;
							wr.addr    = idx_s1;
							wr.key     = req_q.key_tag;
						end else begin
							// lowest count wins, later index on a tie
							if (take) begin
								low_d     = rd.cnt;
								low_idx_d = idx_s1;
							end
							if (last) begin
								fin           = 1'b1;
								res_d         = '0;
								res_d.slot    = SLOT_W'(low_idx_d);
								res_d.evicted = 1'b1;
								wr.key_we     = 1'b1;
								wr.cnt_we     = 1'b1;
								wr.addr       = low_idx_d;
								wr.key        = req_q.key_tag;
							end
						end
					end
				end
				if (fin) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign issue = (state_q == ST_SCAN) && !fin && (rd_idx_q < live_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= ACTIVE_RESET;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				active_q <= cfg_data;
			end
			if (in_valid && in_ready) begin
				rd_idx_q <= '0;
				vld_s1   <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + LN_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data;
		end
		if (issue) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		low_q     <= low_d;
		low_idx_q <= low_idx_d;
		res_q     <= res_d;
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`LFU_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> state_q == ST_IDLE, "not idle after reset")
	`LFU_ASSERT(a_s1_in_scan, vld_s1 |-> state_q == ST_SCAN, "scan stage live outside scan")
	`LFU_ASSERT(a_issue_range, issue |-> rd_idx_q < live_n, "read beyond active entries")
	`LFU_ASSERT(a_hit_no_evict, fin |-> !(res_d.hit && res_d.evicted), "hit and evict together")
	`LFU_ASSERT(a_insert_writes, fin && req_q.action == ACT_INSERT |-> wr.key_we, "insert without write")

endmodule

### tb/sv/lfu_tag_table_checker.sv
`timescale 1ns / 100ps
// Checker for the LFU tag table: watches the item, result and register channels,
// keeps its own copy of the table to predict every result, and counts mismatches.
// Depends on lfu_pkg for the payload types and sizes.
module lfu_tag_table_checker
	import lfu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_t              in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_t             out_data,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending,
	output int               hit_total,
	output int               evict_total
);

	logic [KEY_W-1:0] tag_mem  [ENTRIES];
	logic             tag_live [ENTRIES];
	logic [USE_W-1:0] use_cnt  [ENTRIES];
	logic [CFG_W-1:0] active_cfg;
	out_t             replies_due[$];
	int               fails_seen;
	int               hits_seen;
	int               evicts_seen;

	// Applies one lookup or insert to the shadow table and returns its result.
	function automatic out_t resolve_request(in_t req);
		int               n;
		int               pick;
		bit               stop;
		logic [USE_W-1:0] lowest;
		out_t             r;
		n = (active_cfg == 0) ? 1 : ((active_cfg > ENTRIES) ? ENTRIES : int'(active_cfg));
		r = '0;
		stop = 1'b0;
		if (req.action == ACT_LOOKUP) begin
			// scan ends at the first empty entry
			for (int i = 0; i < n && !stop; i++) begin
				if (!tag_live[i]) begin
					stop = 1'b1;
				end else if (tag_mem[i] == req.key_tag) begin
					stop = 1'b1;
					r.hit = 1'b1;
					r.slot = SLOT_W'(i);
					if (use_cnt[i] != '1)
						use_cnt[i] = use_cnt[i] + 1'b1;
				end
			end
		end else begin
			pick = -1;
			for (int i = 0; i < n && pick < 0; i++) begin
				if (!tag_live[i])
					pick = i;
			end
			if (pick < 0) begin
				// full: lowest count wins, last index on a tie
				lowest = use_cnt[0];
				pick = 0;
				for (int i = 0; i < n; i++) begin
					if (use_cnt[i] <= lowest) begin
						lowest = use_cnt[i];
						pick = i;
					end
				end
				r.evicted = 1'b1;
			end
			tag_mem[pick] = req.key_tag;
			tag_live[pick] = 1'b1;
			use_cnt[pick] = '0;
			r.slot = SLOT_W'(pick);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				tag_mem[i] = '0;
				tag_live[i] = 1'b0;
				use_cnt[i] = '0;
			end
			active_cfg = ACTIVE_RESET;
			replies_due.delete();
			fails_seen = 0;
			hits_seen = 0;
			evicts_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				active_cfg = cfg_data;
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					fails_seen++;
					$error("result with nothing pending: hit %0d slot %0d evicted %0d",
						out_data.hit, out_data.slot, out_data.evicted);
				end else begin
					want = replies_due.pop_front();
					if (out_data.hit !== want.hit) begin
						fails_seen++;
						$error("hit: expected %0d, actual %0d", want.hit, out_data.hit);
					end
					if (out_data.slot !== want.slot) begin
						fails_seen++;
						$error("slot: expected %0d, actual %0d", want.slot, out_data.slot);
					end
					if (out_data.evicted !== want.evicted) begin
						fails_seen++;
						$error("evicted: expected %0d, actual %0d", want.evicted,
							out_data.evicted);
					end
					hits_seen += want.hit;
					evicts_seen += want.evicted;
				end
			end
			if (in_valid && in_ready)
				replies_due.push_back(resolve_request(in_data));
		end
		fail_count <= fails_seen;
		pending <= replies_due.size();
		hit_total <= hits_seen;
		evict_total <= evicts_seen;
	end

endmodule

### tb/sv/tb_lfu_cache_tag_table_core.sv
`timescale 1ns / 100ps
// Testbench top for lfu_cache_tag_table_core: clock, reset, item and register
// stimulus with random idling, watchdog and verdict. Depends on lfu_pkg and
// lfu_tag_table_checker, which does all prediction and comparison.
module tb_lfu_cache_tag_table_core;
	import lfu_pkg::*;

	localparam int LONG_HOLD    = 300;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASES       = 12;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	int               fail_count;
	int               pending;
	int               hit_total;
	int               evict_total;
	int               quiet_cycles = 0;
	int               items_sent = 0;
	bit               idle_on = 1'b0;
	bit               long_hold_req = 1'b0;
	logic [KEY_W-1:0] key_pool[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lfu_cache_tag_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	lfu_tag_table_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.hit_total   (hit_total),
		.evict_total (evict_total)
	);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: short random stalls, plus one long hold-off on request
	initial begin : receiver
		bit held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (long_hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_request(input logic act, input logic [KEY_W-1:0] key);
		in_t req;
		req.action = act;
		req.key_tag = key;
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		if (act == ACT_INSERT) begin
			key_pool.push_back(key);
			if (key_pool.size() > 300)
				void'(key_pool.pop_front());
		end
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// stop offering items and wait for every pending result
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_active(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int               plan[PHASES];
		int               n_items;
		int               ins_pct;
		int               live;
		int               span;
		logic             act;
		logic [KEY_W-1:0] key;
		plan = '{4, 1, 128, 2, 16, 200, 7, 0, 255, 3, 12, 64};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, still at the reset size of 10 entries
		send_request(ACT_LOOKUP, 32'h0000_0000);
		send_request(ACT_INSERT, 32'h0000_0000);
		send_request(ACT_INSERT, 32'hFFFF_FFFF);
		send_request(ACT_LOOKUP, 32'hFFFF_FFFF);
		send_request(ACT_INSERT, 32'h0000_0000);   // duplicate, lower copy wins
		send_request(ACT_LOOKUP, 32'h0000_0000);
		send_request(ACT_INSERT, 32'hA5A5_A5A5);
		send_request(ACT_INSERT, 32'h5A5A_5A5A);
		send_request(ACT_INSERT, 32'h8000_0000);
		send_request(ACT_INSERT, 32'h0000_0001);
		send_request(ACT_INSERT, 32'h7FFF_FFFF);
		send_request(ACT_INSERT, 32'hFFFF_FFFE);
		send_request(ACT_INSERT, 32'h0F0F_0F0F);
		send_request(ACT_LOOKUP, 32'h5A5A_5A5A);
		send_request(ACT_LOOKUP, 32'h8000_0000);
		send_request(ACT_INSERT, 32'h1234_5678);   // full: evicts last zero count
		send_request(ACT_LOOKUP, 32'h0F0F_0F0F);
		// zero acts as one entry
		set_active(8'd0);
		send_request(ACT_INSERT, 32'hDEAD_BEEF);
		send_request(ACT_LOOKUP, 32'hDEAD_BEEF);
		send_request(ACT_LOOKUP, 32'hFFFF_FFFF);
		// oversized value caps at the table size; hidden entries come back
		set_active(8'd255);
		send_request(ACT_LOOKUP, 32'hFFFF_FFFF);
		send_request(ACT_LOOKUP, 32'hCAFE_F00D);
		send_request(ACT_INSERT, 32'hCAFE_F00D);

		for (int p = 0; p < PHASES; p++) begin
			set_active(CFG_W'(plan[p]));
			live = (plan[p] == 0) ? 1 : ((plan[p] > ENTRIES) ? ENTRIES : plan[p]);
			n_items = (plan[p] >= ENTRIES) ? 110 : 35;
			ins_pct = (plan[p] >= ENTRIES) ? 80 : 45;
			idle_on <= (p < PHASES - 2 && p != 3) ? ($urandom_range(0, 3) != 0) : 1'b0;
			if (p == 3)
				long_hold_req <= 1'b1;   // sender keeps going, block backs up
			for (int k = 0; k < n_items; k++) begin
				act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_LOOKUP;
				if (key_pool.size() > 0 &&
				    $urandom_range(0, 99) < ((act == ACT_INSERT) ? 25 : 80)) begin
					// recent keys are the ones most likely still resident
					span = key_pool.size() - 1;
					if (span > 2 * live + 4)
						span = 2 * live + 4;
					key = key_pool[key_pool.size() - 1 - $urandom_range(0, span)];
				end else begin
					key = $urandom();
				end
				send_request(act, key);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d items over %0d table sizes plus directed cases:", items_sent,
			PHASES);
		$display("  %0d lookup hits, %0d evictions.", hit_total, evict_total);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
